FILE: rtl/qpt_pkg.sv
// Package for the query path tokenizer: limits, widths, status and kind codes,
// the result record and the character class helpers.
// No dependencies.
`default_nettype none

package qpt_pkg;

    localparam int MAX_NAME_LEN = 255;
    localparam int MAX_SEGMENTS = 16;
    localparam int MAX_LEVELS   = 16;
    localparam int HEX_DIGITS   = 16;

    localparam int NAME_LEN_W = 8;
    localparam int CNT_W      = 5;
    localparam int INDEX_W    = 64;

    localparam logic [1:0] KIND_HEAD    = 2'd0;
    localparam logic [1:0] KIND_SEGMENT = 2'd1;
    localparam logic [1:0] KIND_CAST    = 2'd2;
    localparam logic [1:0] KIND_DEREF   = 2'd3;

    localparam logic [1:0] ST_BUSY    = 2'd0;
    localparam logic [1:0] ST_ACCEPT  = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;
    localparam logic [1:0] ST_DISCARD = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_RBRK  = 8'h5d;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_UNDER = 8'h5f;

    typedef struct packed {
        logic               is_name_char;
        logic [1:0]         name_kind;
        logic [7:0]         name_char;
        logic               starts_name;
        logic               closes_name;
        logic               index_valid;
        logic [INDEX_W-1:0] index_value;
        logic [1:0]         parse_status;
    } t_result;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alnum(c) || (c == CH_UNDER);
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/qpt_parser.sv
// Tokenizer state machine: parse state and the combinational result for the
// current byte. State advances on each accepted transaction. Uses qpt_pkg.
`default_nettype none

module qpt_parser
    import qpt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_byte,
    output t_result         o_res
);

    typedef enum logic [3:0] {
        PH_HEAD_START  = 4'd0,
        PH_HEAD_NAME   = 4'd1,
        PH_SEG_START   = 4'd2,
        PH_SEG_NAME    = 4'd3,
        PH_CAST_START  = 4'd4,
        PH_CAST_NAME   = 4'd5,
        PH_IDX_ZERO    = 4'd6,
        PH_IDX_X       = 4'd7,
        PH_IDX_HEX     = 4'd8,
        PH_IDX_CLOSE   = 4'd9,
        PH_AFTER_IDX   = 4'd10,
        PH_ARROW       = 4'd11,
        PH_DEREF_START = 4'd12,
        PH_DEREF_NAME  = 4'd13,
        PH_DISCARD     = 4'd14
    } t_phase;

    typedef enum logic [1:0] {
        GO_PHASE,
        GO_ERROR,
        GO_ACCEPT
    } t_go;

    localparam logic [NAME_LEN_W-1:0] NAME_LIMIT = NAME_LEN_W'(MAX_NAME_LEN - 1);
    localparam logic [CNT_W-1:0]      SEG_LIMIT  = CNT_W'(MAX_SEGMENTS);
    localparam logic [CNT_W-1:0]      LVL_LIMIT  = CNT_W'(MAX_LEVELS);
    localparam logic [CNT_W-1:0]      HEX_LIMIT  = CNT_W'(HEX_DIGITS);

    t_phase                r_phase,    n_phase;
    logic [NAME_LEN_W-1:0] r_name_len, n_name_len;
    logic                  r_prev,     n_prev;
    logic [CNT_W-1:0]      r_seg,      n_seg;
    logic [CNT_W-1:0]      r_lvl,      n_lvl;
    logic [CNT_W-1:0]      r_hex,      n_hex;
    logic [INDEX_W-1:0]    r_acc,      n_acc;

    t_go        go;
    t_phase     tgt;
    logic       fol, colon_ok, bracket_ok, close_cand, restart;
    logic [4:0] hv;
    t_result    res;

    function automatic logic [1:0] kind_of(input t_phase p);
        logic [1:0] k;
        case (p)
            PH_HEAD_START, PH_HEAD_NAME:   k = KIND_HEAD;
            PH_SEG_START, PH_SEG_NAME:     k = KIND_SEGMENT;
            PH_CAST_START, PH_CAST_NAME:   k = KIND_CAST;
            PH_DEREF_START, PH_DEREF_NAME: k = KIND_DEREF;
            default:                       k = KIND_HEAD;
        endcase
        return k;
    endfunction

    always_comb begin
        n_phase    = r_phase;
        n_name_len = r_name_len;
        n_prev     = r_prev;
        n_seg      = r_seg;
        n_lvl      = r_lvl;
        n_hex      = r_hex;
        n_acc      = r_acc;
        res        = '0;
        go         = GO_ERROR;
        tgt        = PH_DISCARD;
        fol        = 1'b0;
        colon_ok   = 1'b0;
        bracket_ok = 1'b0;
        close_cand = 1'b0;
        restart    = 1'b0;
        hv         = hex_val(i_byte);

        case (r_phase)
            PH_HEAD_START, PH_SEG_START, PH_CAST_START, PH_DEREF_START: begin
                if (is_alnum(i_byte)) begin
                    res.is_name_char = 1'b1;
                    res.starts_name  = 1'b1;
                    res.name_char    = i_byte;
                    res.name_kind    = kind_of(r_phase);
                    n_name_len       = NAME_LEN_W'(1);
                    n_prev           = 1'b1;
                    go               = GO_PHASE;
                    tgt              = t_phase'(r_phase + 4'd1);
                end
            end
            PH_HEAD_NAME, PH_SEG_NAME, PH_CAST_NAME, PH_DEREF_NAME: begin
                res.name_kind = kind_of(r_phase);
                if (is_word(i_byte)) begin
                    if (r_name_len < NAME_LIMIT) begin
                        res.is_name_char = 1'b1;
                        res.name_char    = i_byte;
                        n_name_len       = r_name_len + NAME_LEN_W'(1);
                        n_prev           = is_alnum(i_byte);
                        go               = GO_PHASE;
                        tgt              = r_phase;
                    end
                end else if (r_prev) begin
                    close_cand = 1'b1;
                    case (r_phase)
                        PH_HEAD_NAME: begin
                            if (i_byte == CH_DOT) begin
                                n_seg = '0;
                                go    = GO_PHASE;
                                tgt   = PH_SEG_START;
                            end
                        end
                        PH_SEG_NAME: begin
                            fol        = 1'b1;
                            colon_ok   = 1'b1;
                            bracket_ok = 1'b1;
                        end
                        PH_CAST_NAME: begin
                            fol        = 1'b1;
                            bracket_ok = 1'b1;
                        end
                        default: begin
                            if (i_byte == CH_DOT && r_lvl < LVL_LIMIT) begin
                                n_lvl = r_lvl + CNT_W'(1);
                                n_seg = '0;
                                go    = GO_PHASE;
                                tgt   = PH_SEG_START;
                            end
                        end
                    endcase
                end
            end
            PH_IDX_ZERO: begin
                if (i_byte == CH_ZERO) begin
                    go  = GO_PHASE;
                    tgt = PH_IDX_X;
                end
            end
            PH_IDX_X: begin
                if (i_byte == CH_X) begin
                    n_acc = '0;
                    n_hex = '0;
                    go    = GO_PHASE;
                    tgt   = PH_IDX_HEX;
                end
            end
            PH_IDX_HEX: begin
                if (hv[4]) begin
                    n_acc = {r_acc[INDEX_W-5:0], hv[3:0]};
                    n_hex = r_hex + CNT_W'(1);
                    go    = GO_PHASE;
                    tgt   = (n_hex >= HEX_LIMIT) ? PH_IDX_CLOSE : PH_IDX_HEX;
                end
            end
            PH_IDX_CLOSE: begin
                if (i_byte == CH_RBRK) begin
                    res.index_valid = 1'b1;
                    res.index_value = r_acc;
                    go              = GO_PHASE;
                    tgt             = PH_AFTER_IDX;
                end
            end
            PH_AFTER_IDX: begin
                fol = 1'b1;
            end
            PH_ARROW: begin
                if (i_byte == CH_GT) begin
                    go  = GO_PHASE;
                    tgt = PH_DEREF_START;
                end
            end
            PH_DISCARD: begin
                res.parse_status = ST_DISCARD;
                restart          = (i_byte == CH_NUL);
            end
            default: begin
                go = GO_ERROR;
            end
        endcase

        if (fol) begin
            if (i_byte == CH_DOT) begin
                n_seg = r_seg + CNT_W'(1);
                if (n_seg < SEG_LIMIT) begin
                    go  = GO_PHASE;
                    tgt = PH_SEG_START;
                end
            end else if (i_byte == CH_COLON && colon_ok) begin
                go  = GO_PHASE;
                tgt = PH_CAST_START;
            end else if (i_byte == CH_LBRK && bracket_ok) begin
                go  = GO_PHASE;
                tgt = PH_IDX_ZERO;
            end else if (i_byte == CH_DASH) begin
                go  = GO_PHASE;
                tgt = PH_ARROW;
            end else if (i_byte == CH_NUL) begin
                go = GO_ACCEPT;
            end
        end

        res.closes_name = close_cand && (go != GO_ERROR);

        if (r_phase == PH_DISCARD) begin
            // status already set
        end else if (go == GO_ERROR) begin
            res              = '0;
            res.parse_status = ST_ERROR;
            if (i_byte == CH_NUL) begin
                restart = 1'b1;
            end else begin
                n_phase = PH_DISCARD;
            end
        end else if (go == GO_ACCEPT) begin
            res.parse_status = ST_ACCEPT;
            restart          = 1'b1;
        end else begin
            n_phase = tgt;
        end

        if (!res.is_name_char && !res.closes_name) begin
            res.name_kind = KIND_HEAD;
        end

        if (restart) begin
            n_phase    = PH_HEAD_START;
            n_name_len = '0;
            n_prev     = 1'b0;
            n_seg      = '0;
            n_lvl      = '0;
            n_hex      = '0;
            n_acc      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEAD_START;
            r_name_len <= '0;
            r_prev     <= 1'b0;
            r_seg      <= '0;
            r_lvl      <= '0;
            r_hex      <= '0;
            r_acc      <= '0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_name_len <= n_name_len;
            r_prev     <= n_prev;
            r_seg      <= n_seg;
            r_lvl      <= n_lvl;
            r_hex      <= n_hex;
            r_acc      <= n_acc;
        end
    end

    assign o_res = res;

endmodule

`default_nettype wire

FILE: rtl/query_path_tokenizer_unit.sv
// Query path tokenizer top level: parser plus a two-entry output buffer.
// Each accepted byte's result is registered into the output register, or into the skid entry while the output waits.
// Throughput: one byte per cycle while o_stall is low; the parse state is registered and feeds back to the next byte.
// The output buffer keeps input flowing while one result waits downstream.
// Reset (i_rst_n low, synchronous) clears parse state and empties both buffer entries.
// Depends on qpt_pkg and qpt_parser.
`default_nettype none

module query_path_tokenizer_unit
    import qpt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [7:0]         i_query_byte,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_is_name_char,
    output logic [1:0]              o_name_kind,
    output logic [7:0]              o_name_char,
    output logic                    o_starts_name,
    output logic                    o_closes_name,
    output logic                    o_index_valid,
    output logic [INDEX_W-1:0]      o_index_value,
    output logic [1:0]              o_parse_status
);

    t_result res;
    t_result r_out, r_skid;
    logic    r_out_vld, r_skid_vld;
    logic    in_acc, out_acc;

    assign in_acc  = i_valid && !r_skid_vld;
    assign out_acc = r_out_vld && !i_stall;

    qpt_parser u_parser (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (in_acc),
        .i_byte (i_query_byte),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (out_acc) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (in_acc) begin
            if (r_out_vld && !out_acc) begin
                r_skid     <= res;
                r_skid_vld <= 1'b1;
            end else begin
                r_out     <= res;
                r_out_vld <= 1'b1;
            end
        end else if (out_acc) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_stall        = r_skid_vld;
    assign o_valid        = r_out_vld;
    assign o_is_name_char = r_out.is_name_char;
    assign o_name_kind    = r_out.name_kind;
    assign o_name_char    = r_out.name_char;
    assign o_starts_name  = r_out.starts_name;
    assign o_closes_name  = r_out.closes_name;
    assign o_index_valid  = r_out.index_valid;
    assign o_index_value  = r_out.index_value;
    assign o_parse_status = r_out.parse_status;

endmodule

`default_nettype wire

FILE: rtl/qpt_checker.sv
// Port-level checks for query_path_tokenizer_unit, bound to the top level.
// Depends on qpt_pkg.
`default_nettype none

module qpt_checker
    import qpt_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic               o_is_name_char,
    input wire logic [1:0]         o_name_kind,
    input wire logic [7:0]         o_name_char,
    input wire logic               o_starts_name,
    input wire logic               o_closes_name,
    input wire logic               o_index_valid,
    input wire logic [INDEX_W-1:0] o_index_value,
    input wire logic [1:0]         o_parse_status
);

    // stalled transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_parse_status) &&
        $stable(o_name_char) && $stable(o_index_value))
        else $error("output changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_parse_status == ST_ERROR || o_parse_status == ST_DISCARD) |->
        !o_is_name_char && !o_closes_name && !o_index_valid && o_name_kind == KIND_HEAD)
        else $error("error or discard transaction carries token data");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_starts_name |-> o_is_name_char && !o_closes_name)
        else $error("name start without name character");

    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_index_valid |-> o_index_value == '0)
        else $error("index value without index");

    // input stalls only while both buffer entries are full
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

endmodule

bind query_path_tokenizer_unit qpt_checker u_qpt_checker (.*);

`default_nettype wire

FILE: tb/sv/query_path_tokenizer_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for query_path_tokenizer_unit: directed byte table, then random queries,
// every result checked against its golden table row if typed, else a tokenizer predictor in the testbench.
// Depends on qpt_pkg and the query_path_tokenizer_unit RTL.

module query_path_tokenizer_unit_tb;
    import qpt_pkg::*;

    localparam int RAND_ITEMS = 800;
    localparam int NXT_FAIL   = -1;
    localparam int NXT_DONE   = -2;

    typedef enum logic [3:0] {
        P_HEAD_BEGIN  = 4'd0,  P_HEAD_BODY  = 4'd1,  P_SEG_BEGIN = 4'd2,
        P_SEG_BODY    = 4'd3,  P_CAST_BEGIN = 4'd4,  P_CAST_BODY = 4'd5,
        P_IDX_LEAD    = 4'd6,  P_IDX_RADIX  = 4'd7,  P_IDX_DIGITS = 4'd8,
        P_IDX_END     = 4'd9,  P_POST_IDX   = 4'd10, P_ARROW_TIP = 4'd11,
        P_DEREF_BEGIN = 4'd12, P_DEREF_BODY = 4'd13, P_SKIP      = 4'd14
    } t_tok_phase;

    typedef struct {
        logic [7:0] qbyte;
        bit         typed;
        t_result    golden;
    } t_stim;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_query_byte;
    logic               o_valid;
    logic               i_stall;
    logic               o_is_name_char;
    logic [1:0]         o_name_kind;
    logic [7:0]         o_name_char;
    logic               o_starts_name;
    logic               o_closes_name;
    logic               o_index_valid;
    logic [INDEX_W-1:0] o_index_value;
    logic [1:0]         o_parse_status;

    // tokenizer predictor state
    t_tok_phase         tk_phase;
    logic [7:0]         tk_len;
    logic               tk_alnum;
    logic [4:0]         tk_segs;
    logic [4:0]         tk_levels;
    logic [4:0]         tk_digits;
    logic [63:0]        tk_acc;

    t_result            expected_q[$];
    t_stim              dir_table[$];
    logic [7:0]         qbuf[$];
    t_stim              cur_stim;
    t_result            want_res;
    bit                 idle_on;
    int                 fail_count;
    string              alnum_set;
    string              hex_set;

    query_path_tokenizer_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_query_byte   (i_query_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_is_name_char (o_is_name_char),
        .o_name_kind    (o_name_kind),
        .o_name_char    (o_name_char),
        .o_starts_name  (o_starts_name),
        .o_closes_name  (o_closes_name),
        .o_index_valid  (o_index_valid),
        .o_index_value  (o_index_value),
        .o_parse_status (o_parse_status)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic bit alnum_ch(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function automatic logic [1:0] name_kind_of(input t_tok_phase ph);
        case (ph)
            P_HEAD_BEGIN, P_HEAD_BODY: return KIND_HEAD;
            P_SEG_BEGIN, P_SEG_BODY:   return KIND_SEGMENT;
            P_CAST_BEGIN, P_CAST_BODY: return KIND_CAST;
            default:                   return KIND_DEREF;
        endcase
    endfunction

    function automatic void restart_tokenizer();
        tk_phase  = P_HEAD_BEGIN;
        tk_len    = '0;
        tk_alnum  = 1'b0;
        tk_segs   = '0;
        tk_levels = '0;
        tk_digits = '0;
        tk_acc    = '0;
    endfunction

    // delimiter after a segment, cast or index
    function automatic int after_token(input logic [7:0] c, input bit colon_ok,
                                       input bit bracket_ok);
        if (c == CH_DOT) begin
            tk_segs = tk_segs + 5'd1;
            return (tk_segs >= MAX_SEGMENTS) ? NXT_FAIL : int'(P_SEG_BEGIN);
        end
        if (c == CH_COLON && colon_ok) return int'(P_CAST_BEGIN);
        if (c == CH_LBRK && bracket_ok) return int'(P_IDX_LEAD);
        if (c == CH_DASH) return int'(P_ARROW_TIP);
        if (c == CH_NUL) return NXT_DONE;
        return NXT_FAIL;
    endfunction

    function automatic t_result tokenize_byte(input logic [7:0] c);
        t_result    r;
        t_tok_phase ph;
        int         nxt;
        logic [3:0] digit;
        bit         digit_ok;
        r   = '0;
        ph  = tk_phase;
        nxt = NXT_FAIL;
        case (ph)
            P_HEAD_BEGIN, P_SEG_BEGIN, P_CAST_BEGIN, P_DEREF_BEGIN: begin
                if (alnum_ch(c)) begin
                    r.is_name_char = 1'b1;
                    r.starts_name  = 1'b1;
                    r.name_char    = c;
                    r.name_kind    = name_kind_of(ph);
                    tk_len   = 8'd1;
                    tk_alnum = 1'b1;
                    nxt = int'(ph) + 1;
                end
            end
            P_HEAD_BODY, P_SEG_BODY, P_CAST_BODY, P_DEREF_BODY: begin
                if (alnum_ch(c) || c == CH_UNDER) begin
                    if (tk_len < 8'(MAX_NAME_LEN - 1)) begin
                        r.is_name_char = 1'b1;
                        r.name_char    = c;
                        r.name_kind    = name_kind_of(ph);
                        tk_len   = tk_len + 8'd1;
                        tk_alnum = alnum_ch(c);
                        nxt = int'(ph);
                    end
                end else if (tk_alnum) begin
                    case (ph)
                        P_HEAD_BODY: begin
                            if (c == CH_DOT) begin
                                tk_segs = '0;
                                nxt = int'(P_SEG_BEGIN);
                            end
                        end
                        P_SEG_BODY:  nxt = after_token(c, 1'b1, 1'b1);
                        P_CAST_BODY: nxt = after_token(c, 1'b0, 1'b1);
                        default: begin
                            if (c == CH_DOT && tk_levels < MAX_LEVELS) begin
                                tk_levels = tk_levels + 5'd1;
                                tk_segs   = '0;
                                nxt = int'(P_SEG_BEGIN);
                            end
                        end
                    endcase
                    if (nxt != NXT_FAIL) begin
                        r.closes_name = 1'b1;
                        r.name_kind   = name_kind_of(ph);
                    end
                end
            end
            P_IDX_LEAD: if (c == CH_ZERO) nxt = int'(P_IDX_RADIX);
            P_IDX_RADIX: begin
                if (c == CH_X) begin
                    tk_acc    = '0;
                    tk_digits = '0;
                    nxt = int'(P_IDX_DIGITS);
                end
            end
            P_IDX_DIGITS: begin
                digit_ok = 1'b1;
                digit    = '0;
                if (c >= 8'h30 && c <= 8'h39) digit = 4'(c - 8'h30);
                else if (c >= 8'h61 && c <= 8'h66) digit = 4'(c - 8'h61 + 8'd10);
                else if (c >= 8'h41 && c <= 8'h46) digit = 4'(c - 8'h41 + 8'd10);
                else digit_ok = 1'b0;
                if (digit_ok) begin
                    tk_acc    = {tk_acc[59:0], digit};
                    tk_digits = tk_digits + 5'd1;
                    nxt = (tk_digits >= HEX_DIGITS) ? int'(P_IDX_END) : int'(P_IDX_DIGITS);
                end
            end
            P_IDX_END: begin
                if (c == CH_RBRK) begin
                    r.index_valid = 1'b1;
                    r.index_value = tk_acc;
                    nxt = int'(P_POST_IDX);
                end
            end
            P_POST_IDX:  nxt = after_token(c, 1'b0, 1'b0);
            P_ARROW_TIP: if (c == CH_GT) nxt = int'(P_DEREF_BEGIN);
            P_SKIP: begin
                r.parse_status = ST_DISCARD;
                if (c == CH_NUL) restart_tokenizer();
            end
            default: ;
        endcase

        if (ph == P_SKIP) begin
        end else if (nxt == NXT_FAIL) begin
            r = '0;
            r.parse_status = ST_ERROR;
            if (c == CH_NUL) restart_tokenizer();
            else tk_phase = P_SKIP;
        end else if (nxt == NXT_DONE) begin
            r.parse_status = ST_ACCEPT;
            restart_tokenizer();
        end else begin
            tk_phase = t_tok_phase'(4'(nxt));
        end
        return r;
    endfunction

    function automatic void field_check(input string fname, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, fname, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                want_res = tokenize_byte(i_query_byte);
                if (cur_stim.typed) want_res = cur_stim.golden;
                expected_q.push_back(want_res);
            end
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected transaction: expected none, actual status %0d",
                             $time, o_parse_status);
                    fail_count++;
                end else begin
                    want_res = expected_q.pop_front();
                    field_check("is_name_char", 64'(want_res.is_name_char),
                                64'(o_is_name_char));
                    field_check("name_kind", 64'(want_res.name_kind), 64'(o_name_kind));
                    field_check("name_char", 64'(want_res.name_char), 64'(o_name_char));
                    field_check("starts_name", 64'(want_res.starts_name),
                                64'(o_starts_name));
                    field_check("closes_name", 64'(want_res.closes_name),
                                64'(o_closes_name));
                    field_check("index_valid", 64'(want_res.index_valid),
                                64'(o_index_valid));
                    field_check("index_value", want_res.index_value, o_index_value);
                    field_check("parse_status", 64'(want_res.parse_status),
                                64'(o_parse_status));
                end
            end
        end
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= idle_on && ($urandom_range(0, 99) < 10);
        end
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_byte(input t_stim s);
        while (idle_on && $urandom_range(0, 99) < 10) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_query_byte <= s.qbyte;
        cur_stim = s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (expected_q.size() != 0);
    endtask

    task automatic add_row(input logic [7:0] b, input bit typed, input t_result g);
        t_stim s;
        s.qbyte  = b;
        s.typed  = typed;
        s.golden = g;
        dir_table.push_back(s);
    endtask

    task automatic push_name(input int n);
        qbuf.push_back(alnum_set[$urandom_range(0, 61)]);
        for (int k = 1; k < n; k++) begin
            if (k < n - 1 && $urandom_range(0, 4) == 0) qbuf.push_back(CH_UNDER);
            else qbuf.push_back(alnum_set[$urandom_range(0, 61)]);
        end
    endtask

    task automatic build_query(input int qn);
        int         mode;
        int         levels;
        int         segs;
        int         pos;
        bit         tiny;
        bit         zero_idx;
        logic [7:0] junk;
        qbuf.delete();
        mode = $urandom_range(0, 99);
        if (mode < 10) begin
            repeat ($urandom_range(1, 12)) qbuf.push_back(8'($urandom_range(0, 255)));
            qbuf.push_back(CH_NUL);
            return;
        end
        // segment and level limit queries use one-character segment and deref names
        tiny = (qn % 8 == 3) || (qn % 8 == 6);
        push_name((qn % 12 == 2) ? $urandom_range(253, 256) : $urandom_range(1, 6));
        qbuf.push_back(CH_DOT);
        if (qn % 8 == 6) levels = $urandom_range(15, 17);
        else levels = ($urandom_range(0, 99) < 55) ? 0 : $urandom_range(1, 2);
        for (int lv = 0; lv <= levels; lv++) begin
            if (qn % 8 == 3 && lv == 0) segs = $urandom_range(15, 17);
            else segs = tiny ? 1 : $urandom_range(1, 3);
            for (int sg = 0; sg < segs; sg++) begin
                if (sg != 0) qbuf.push_back(CH_DOT);
                push_name(tiny ? 1 : $urandom_range(1, 6));
                if (!tiny && $urandom_range(0, 99) < 25) begin
                    qbuf.push_back(CH_COLON);
                    push_name($urandom_range(1, 6));
                end
                if (!tiny && $urandom_range(0, 99) < 15) begin
                    qbuf.push_back(CH_LBRK);
                    qbuf.push_back(CH_ZERO);
                    qbuf.push_back(CH_X);
                    zero_idx = ($urandom_range(0, 7) == 0);
                    repeat (HEX_DIGITS)
                        qbuf.push_back(zero_idx ? CH_ZERO : hex_set[$urandom_range(0, 21)]);
                    qbuf.push_back(CH_RBRK);
                end
            end
            if (lv < levels) begin
                qbuf.push_back(CH_DASH);
                qbuf.push_back(CH_GT);
                push_name(tiny ? 1 : $urandom_range(1, 6));
                qbuf.push_back(CH_DOT);
            end
        end
        qbuf.push_back(CH_NUL);
        if (mode < 32) begin
            pos = $urandom_range(0, qbuf.size() - 1);
            case ($urandom_range(0, 11))
                0:       junk = CH_NUL;
                1:       junk = CH_DOT;
                2:       junk = CH_COLON;
                3:       junk = CH_LBRK;
                4:       junk = CH_RBRK;
                5:       junk = CH_DASH;
                6:       junk = CH_GT;
                7:       junk = CH_UNDER;
                8:       junk = CH_ZERO;
                9:       junk = CH_X;
                10:      junk = "X";
                default: junk = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 2))
                0:       qbuf[pos] = junk;
                1:       qbuf.insert(pos, junk);
                default: qbuf.delete(pos);
            endcase
        end
    endtask

    initial begin
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_stim s;
        int    qn;
        int    rand_bytes;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_query_byte = 8'h00;
        idle_on      = 1'b1;
        fail_count   = 0;
        cur_stim     = '{qbyte: 8'h00, typed: 1'b0, golden: '0};
        alnum_set    = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
        hex_set      = "0123456789abcdefABCDEF";
        restart_tokenizer();

        // zero byte right after reset, underscore before a delimiter, discard run
        add_row(CH_NUL, 1'b1, {1'b0, KIND_HEAD, 8'h00, 3'b000, 64'h0, ST_ERROR});
        add_row("A",    1'b1, {1'b1, KIND_HEAD, 8'h41, 3'b100, 64'h0, ST_BUSY});
        add_row("_",    1'b0, '0);
        add_row(CH_DOT, 1'b1, {1'b0, KIND_HEAD, 8'h00, 3'b000, 64'h0, ST_ERROR});
        add_row(8'hff,  1'b1, {1'b0, KIND_HEAD, 8'h00, 3'b000, 64'h0, ST_DISCARD});
        add_row(CH_NUL, 1'b1, {1'b0, KIND_HEAD, 8'h00, 3'b000, 64'h0, ST_DISCARD});
        // largest index, then end of query
        add_row("h",     1'b0, '0);
        add_row(CH_DOT,  1'b0, '0);
        add_row("s",     1'b0, '0);
        add_row(CH_LBRK, 1'b0, '0);
        add_row(CH_ZERO, 1'b0, '0);
        add_row(CH_X,    1'b0, '0);
        for (int k = 0; k < HEX_DIGITS; k++) add_row((k % 2) ? "F" : "f", 1'b0, '0);
        add_row(CH_RBRK, 1'b1, {1'b0, KIND_HEAD, 8'h00, 3'b001, 64'hffff_ffff_ffff_ffff,
                                ST_BUSY});
        add_row(CH_NUL,  1'b1, {1'b0, KIND_HEAD, 8'h00, 3'b000, 64'h0, ST_ACCEPT});

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_table[k]) send_byte(dir_table[k]);
        drain_results();

        qn         = 0;
        rand_bytes = 0;
        while (rand_bytes < RAND_ITEMS) begin
            build_query(qn);
            foreach (qbuf[k]) begin
                idle_on  = !(rand_bytes >= 300 && rand_bytes < 550);
                s.qbyte  = qbuf[k];
                s.typed  = 1'b0;
                s.golden = '0;
                send_byte(s);
                rand_bytes++;
            end
            if ($urandom_range(0, 9) == 0) drain_results();
            qn++;
        end

        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: query_path_tokenizer_unit.f
rtl/qpt_pkg.sv
rtl/qpt_parser.sv
rtl/query_path_tokenizer_unit.sv
rtl/qpt_checker.sv
tb/sv/query_path_tokenizer_unit_tb.sv
